// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of the token classifier.
// No dependencies; the file is taken in by `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, skipped while reset is high.
`define ASSERT_CLK_DIS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property, checked on every edge including reset.
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/ltc_pkg.sv =====
// Package for the lexer token classifier: class codes, keyword table and
// the info struct passed from the accumulator to the classifier.
// No dependencies.
`default_nettype none

package ltc_pkg;

   localparam int CLASS_W    = 4;
   localparam int KW_MAX_LEN = 6;
   localparam int KW_COUNT   = 7;
   localparam int LEN_W      = 3;

   localparam logic [CLASS_W-1:0] CLS_CMP    = 4'd0;
   localparam logic [CLASS_W-1:0] CLS_ONE    = 4'd1;
   localparam logic [CLASS_W-1:0] CLS_DEF    = 4'd2;
   localparam logic [CLASS_W-1:0] CLS_IF     = 4'd3;
   localparam logic [CLASS_W-1:0] CLS_WHILE  = 4'd4;
   localparam logic [CLASS_W-1:0] CLS_PRINT  = 4'd5;
   localparam logic [CLASS_W-1:0] CLS_READ   = 4'd6;
   localparam logic [CLASS_W-1:0] CLS_END    = 4'd7;
   localparam logic [CLASS_W-1:0] CLS_RETURN = 4'd8;
   localparam logic [CLASS_W-1:0] CLS_NUM    = 4'd9;
   localparam logic [CLASS_W-1:0] CLS_NAME   = 4'd10;
   localparam logic [CLASS_W-1:0] CLS_ERR    = 4'd11;

   // Keyword text, first character in the top byte, zero padded.
   localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [KW_COUNT] = '{
      {"def",    24'h0},
      {"if",     32'h0},
      {"while",  8'h0},
      {"print",  8'h0},
      {"read",   16'h0},
      {"end",    24'h0},
      "return"
   };

   localparam logic [LEN_W-1:0] KW_LEN [KW_COUNT] = '{
      3'd3, 3'd2, 3'd5, 3'd5, 3'd4, 3'd3, 3'd6
   };

   localparam logic [CLASS_W-1:0] KW_CLASS [KW_COUNT] = '{
      CLS_DEF, CLS_IF, CLS_WHILE, CLS_PRINT, CLS_READ, CLS_END, CLS_RETURN
   };

   // Token length beyond any keyword.
   localparam logic [LEN_W-1:0] LEN_LONG = 3'(KW_MAX_LEN + 1);

   typedef struct packed {
      logic [KW_MAX_LEN-1:0][7:0] chars;   // chars[0] is the first character
      logic [LEN_W-1:0]           len;     // 1..6, LEN_LONG when longer
      logic                       digits;  // all characters are digits
      logic                       name;    // letter, then letters/digits/_
   } ltc_info_type;

endpackage

`default_nettype wire

// ===== rtl/core/ltc_accum.sv =====
// Per-token accumulator: character count, prefix buffer and digit/name
// flags, with the current character folded in. Depends on ltc_pkg.
`default_nettype none

module ltc_accum (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 advance,
   input  wire logic [7:0]           char_in,
   input  wire logic                 last_in,
   output ltc_pkg::ltc_info_type     info
);

   localparam int CW = $clog2(ltc_pkg::KW_MAX_LEN + 1);
   localparam int IW = $clog2(ltc_pkg::KW_MAX_LEN);

   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    prefix_ff [ltc_pkg::KW_MAX_LEN];
   logic          digits_ff, digits_in;
   logic          name_ff, name_in;

   logic first, room, is_dig, is_let, nd, nn;

   always_comb begin
      first  = (count_ff == '0);
      room   = (count_ff < CW'(ltc_pkg::KW_MAX_LEN));
      is_dig = (char_in >= "0") && (char_in <= "9");
      is_let = ((char_in >= "a") && (char_in <= "z")) ||
               ((char_in >= "A") && (char_in <= "Z"));
      if (first) begin
         nd = is_dig;
         nn = is_let;
      end else begin
         nd = digits_ff && is_dig;
         nn = name_ff && (is_dig || is_let || (char_in == "_"));
      end

      for (int i = 0; i < ltc_pkg::KW_MAX_LEN; i++) begin
         info.chars[i] = (room && (count_ff == CW'(i))) ? char_in : prefix_ff[i];
      end
      if (count_ff < CW'(ltc_pkg::KW_MAX_LEN)) begin
         info.len = ltc_pkg::LEN_W'(count_ff) + ltc_pkg::LEN_W'(1);
      end else begin
         info.len = ltc_pkg::LEN_LONG;
      end
      info.digits = nd;
      info.name   = nn;

      if (last_in) begin
         count_in  = '0;
         digits_in = 1'b0;
         name_in   = 1'b0;
      end else begin
         count_in  = room ? count_ff + CW'(1) : count_ff;
         digits_in = nd;
         name_in   = nn;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         digits_ff <= 1'b0;
         name_ff   <= 1'b0;
      end else if (advance) begin
         count_ff  <= count_in;
         digits_ff <= digits_in;
         name_ff   <= name_in;
      end
   end

   // prefix buffer, no reset: entries past the current length are never compared
   always_ff @(posedge clock) begin
      if (advance && room) begin
         prefix_ff[count_ff[IW-1:0]] <= char_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/ltc_classify.sv =====
// Token class decode from the accumulated prefix, length and flags.
// Depends on ltc_pkg.
`default_nettype none

module ltc_classify (
   input  wire ltc_pkg::ltc_info_type           info,
   output logic [ltc_pkg::CLASS_W-1:0]          token_class
);

   localparam int BW = 8 * ltc_pkg::KW_MAX_LEN;

   logic [BW-1:0] buf_vec;
   logic [BW-1:0] kw_mask;
   logic [7:0]    c0, c1;
   logic          is_one, is_cmp1, is_cmp2, kw_hit;
   logic [ltc_pkg::CLASS_W-1:0] kw_class;

   always_comb begin
      for (int i = 0; i < ltc_pkg::KW_MAX_LEN; i++) begin
         buf_vec[8*(ltc_pkg::KW_MAX_LEN-1-i) +: 8] = info.chars[i];
      end
      c0 = info.chars[0];
      c1 = info.chars[1];

      is_cmp1 = (info.len == 3'd1) && ((c0 == "<") || (c0 == ">"));
      is_one  = (info.len == 3'd1) &&
                ((c0 == "+") || (c0 == "-") || (c0 == "*") || (c0 == "/") ||
                 (c0 == "=") || (c0 == "(") || (c0 == ")") || (c0 == ":") ||
                 (c0 == ",") || (c0 == 8'h0A));
      is_cmp2 = (info.len == 3'd2) && (c1 == "=") &&
                ((c0 == "=") || (c0 == "!") || (c0 == ">") || (c0 == "<"));

      // keyword texts differ, so at most one hits
      kw_hit   = 1'b0;
      kw_class = ltc_pkg::CLS_ERR;
      kw_mask  = '0;
      for (int k = 0; k < ltc_pkg::KW_COUNT; k++) begin
         kw_mask = ~({BW{1'b1}} >> (8 * int'(ltc_pkg::KW_LEN[k])));
         if ((info.len == ltc_pkg::KW_LEN[k]) &&
             (((buf_vec ^ ltc_pkg::KW_TEXT[k]) & kw_mask) == '0)) begin
            kw_hit   = 1'b1;
            kw_class = ltc_pkg::KW_CLASS[k];
         end
      end

      priority if (is_cmp1 || is_cmp2) begin
         token_class = ltc_pkg::CLS_CMP;
      end else if (is_one) begin
         token_class = ltc_pkg::CLS_ONE;
      end else if (kw_hit) begin
         token_class = kw_class;
      end else if (info.digits) begin
         token_class = ltc_pkg::CLS_NUM;
      end else if (info.name) begin
         token_class = ltc_pkg::CLS_NAME;
      end else begin
         token_class = ltc_pkg::CLS_ERR;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/lexer_token_classifier.sv =====
// Each character is registered into the input stage, then folded into the accumulator;
// on a token's last character the class is registered once the output is free.
// Throughput: one character per cycle; input stalls only while the result waits.
// Reset clears the pipeline valids, count and flags; the prefix buffer is not reset.
// Depends on ltc_pkg, ltc_accum and ltc_classify.
`default_nettype none

module lexer_token_classifier (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [7:0]                      req_in_char,
   input  wire logic                            req_last_char,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [ltc_pkg::CLASS_W-1:0]          rsp_token_class
);

   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_char_ff;
   logic       s1_last_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [ltc_pkg::CLASS_W-1:0] rsp_class_ff, class_in;

   logic out_free, advance, take;
   ltc_pkg::ltc_info_type info;

   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      advance   = s1_valid_ff && out_free;
      req_stall = s1_valid_ff && !out_free;
      take      = req_valid && !req_stall;

      if (take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      rsp_valid_in = out_free ? (advance && s1_last_ff) : rsp_valid_ff;
   end

   ltc_accum u_accum (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .char_in (s1_char_ff),
      .last_in (s1_last_ff),
      .info    (info)
   );

   ltc_classify u_classify (
      .info        (info),
      .token_class (class_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_char_ff <= req_in_char;
         s1_last_ff <= req_last_char;
      end
      if (advance && s1_last_ff) begin
         rsp_class_ff <= class_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_token_class = rsp_class_ff;

endmodule

`default_nettype wire

// ===== rtl/core/ltc_checker.sv =====
// Port-level checker for lexer_token_classifier, bound to the top level.
// Depends on assert_macros.svh and ltc_pkg.
`default_nettype none
`include "assert_macros.svh"

module ltc_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_stall,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_stall,
   input wire logic [ltc_pkg::CLASS_W-1:0] rsp_token_class
);

   `ASSERT_CLK_DIS(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_token_class), "stalled result changed")
   `ASSERT_CLK_DIS(a_class_range, clock, reset, rsp_valid |-> (rsp_token_class <= ltc_pkg::CLS_ERR), "class code out of range")
   `ASSERT_CLK_DIS(a_stall_cause, clock, reset, req_stall |-> rsp_valid && rsp_stall, "input stalled without a waiting result")
   `ASSERT_CLK(a_reset_clear, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind lexer_token_classifier ltc_checker u_ltc_checker (.*);

`default_nettype wire

// ===== test/testbench.sv =====
// Testbench for lexer_token_classifier: character stream in, one class code per token out.
// Depends on ltc_pkg for the class codes and on the classifier RTL.
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int KW_CHARS      = ltc_pkg::KW_MAX_LEN;
   localparam int PHASE_ITEMS   = 200;
   localparam int HOLD_CYCLES   = 80;
   localparam int STUCK_LIMIT   = 1500;
   localparam int DRAIN_CYCLES  = 10;

   typedef struct packed {
      logic [7:0]                  ch;
      logic                        last;
      logic                        typed;   // cls holds the class to expect
      logic [ltc_pkg::CLASS_W-1:0] cls;
   } stim_row_type;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic [7:0]                   req_in_char;
   logic                         req_last_char;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic [ltc_pkg::CLASS_W-1:0]  rsp_token_class;

   // Tracked token state, mirrors what the block keeps between characters
   logic [2:0]          token_count;
   logic [7:0]          token_prefix [KW_CHARS];
   logic                token_digits;
   logic                token_name;

   logic [ltc_pkg::CLASS_W-1:0]  class_queue [$];
   logic [7:0]                   token_bytes [$];
   logic [ltc_pkg::CLASS_W-1:0]  expected_class;

   int                  fail_count;
   int                  send_gap_pct;
   int                  stall_pct;
   int                  hold_left;
   bit                  hold_request;
   int                  stuck_cycles;
   int                  sent_items;

   string keyword_text [ltc_pkg::KW_COUNT] =
      '{"def", "if", "while", "print", "read", "end", "return"};
   logic [7:0] single_chars [10] = '{"+", "-", "*", "/", "=", "(", ")", ":", ",", 8'h0a};
   logic [7:0] cmp_heads [4] = '{"=", "!", ">", "<"};

   stim_row_type directed_rows [21] = '{
      '{"<",   1'b1, 1'b1, ltc_pkg::CLS_CMP},
      '{">",   1'b0, 1'b0, '0},
      '{"=",   1'b1, 1'b0, '0},
      '{8'h0a, 1'b1, 1'b1, ltc_pkg::CLS_ONE},
      '{"=",   1'b1, 1'b1, ltc_pkg::CLS_ONE},
      '{"d",   1'b0, 1'b0, '0},
      '{"e",   1'b0, 1'b0, '0},
      '{"f",   1'b1, 1'b1, ltc_pkg::CLS_DEF},
      '{"r",   1'b0, 1'b0, '0},
      '{"e",   1'b0, 1'b0, '0},
      '{"t",   1'b0, 1'b0, '0},
      '{"u",   1'b0, 1'b0, '0},
      '{"r",   1'b0, 1'b0, '0},
      '{"n",   1'b1, 1'b1, ltc_pkg::CLS_RETURN},
      '{"9",   1'b1, 1'b0, '0},
      '{"x",   1'b0, 1'b0, '0},
      '{"_",   1'b1, 1'b0, '0},
      '{8'hff, 1'b1, 1'b1, ltc_pkg::CLS_ERR},
      '{8'h00, 1'b1, 1'b1, ltc_pkg::CLS_ERR},
      '{"!",   1'b0, 1'b0, '0},
      '{"=",   1'b1, 1'b0, '0}
   };

   lexer_token_classifier uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_char     (req_in_char),
      .req_last_char   (req_last_char),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_token_class (rsp_token_class)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Class of a finished token; len is KW_CHARS+1 once the token outgrew the prefix
   function automatic logic [ltc_pkg::CLASS_W-1:0] classify_token(int unsigned len,
                                                                   logic digits,
                                                                   logic name);
      bit hit;
      if (len == 1) begin
         if (token_prefix[0] == "<" || token_prefix[0] == ">")
            return ltc_pkg::CLS_CMP;
         for (int i = 0; i < 10; i++)
            if (token_prefix[0] == single_chars[i])
               return ltc_pkg::CLS_ONE;
      end
      if (len == 2 && token_prefix[1] == "=") begin
         for (int i = 0; i < 4; i++)
            if (token_prefix[0] == cmp_heads[i])
               return ltc_pkg::CLS_CMP;
      end
      if (len <= KW_CHARS) begin
         for (int k = 0; k < ltc_pkg::KW_COUNT; k++) begin
            if (keyword_text[k].len() == len) begin
               hit = 1'b1;
               for (int i = 0; i < len; i++)
                  if (token_prefix[i] != keyword_text[k][i])
                     hit = 1'b0;
               if (hit)
                  return ltc_pkg::CLASS_W'(ltc_pkg::CLS_DEF + k);
            end
         end
      end
      if (digits)
         return ltc_pkg::CLS_NUM;
      if (name)
         return ltc_pkg::CLS_NAME;
      return ltc_pkg::CLS_ERR;
   endfunction

   // Takes one character into the tracked state; returns 1 when a class is due
   function automatic bit absorb_char(input logic [7:0] c, input logic last,
                                      output logic [ltc_pkg::CLASS_W-1:0] cls);
      logic        is_dig;
      logic        is_let;
      logic        nd;
      logic        nn;
      int unsigned len;
      is_dig = (c >= "0" && c <= "9");
      is_let = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
      if (token_count == 0) begin
         nd = is_dig;
         nn = is_let;
      end else begin
         nd = token_digits && is_dig;
         nn = token_name && (is_dig || is_let || c == "_");
      end
      if (token_count < KW_CHARS) begin
         token_prefix[token_count] = c;
         len = token_count + 1;
         token_count = token_count + 3'd1;
      end else begin
         len = KW_CHARS + 1;
      end
      cls = '0;
      if (!last) begin
         token_digits = nd;
         token_name = nn;
         return 1'b0;
      end
      cls = classify_token(len, nd, nn);
      token_count = '0;
      token_digits = 1'b0;
      token_name = 1'b0;
      return 1'b1;
   endfunction

   task automatic report_mismatch(string what, logic [ltc_pkg::CLASS_W-1:0] want,
                                  logic [ltc_pkg::CLASS_W-1:0] got);
      $display("%0t ns: %s: expected class %0d, got %0d", $realtime, what, want, got);
      fail_count++;
   endtask

   task automatic send_char(input logic [7:0] c, input logic last, input logic typed,
                            input logic [ltc_pkg::CLASS_W-1:0] typed_cls);
      logic [ltc_pkg::CLASS_W-1:0] cls;
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_in_char   <= c;
      req_last_char <= last;
      do @(posedge clock); while (req_stall);
      if (absorb_char(c, last, cls))
         class_queue.push_back(typed ? typed_cls : cls);
   endtask

   task automatic push_text(string s);
      for (int i = 0; i < s.len(); i++)
         token_bytes.push_back(s[i]);
   endtask

   function automatic logic [7:0] random_letter();
      return $urandom_range(0, 1) ? 8'("a" + $urandom_range(0, 25))
                                  : 8'("A" + $urandom_range(0, 25));
   endfunction

   // Mostly well-formed tokens, plus near misses and raw noise
   task automatic build_token();
      int kind;
      int n;
      int pos;
      token_bytes.delete();
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
         push_text(keyword_text[$urandom_range(0, ltc_pkg::KW_COUNT - 1)]);
      end else if (kind < 25) begin
         case ($urandom_range(0, 2))
            0: token_bytes.push_back(single_chars[$urandom_range(0, 9)]);
            1: token_bytes.push_back($urandom_range(0, 1) ? "<" : ">");
            default: begin
               token_bytes.push_back(cmp_heads[$urandom_range(0, 3)]);
               token_bytes.push_back("=");
            end
         endcase
      end else if (kind < 40) begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 4);
         repeat (n) token_bytes.push_back(8'("0" + $urandom_range(0, 9)));
      end else if (kind < 58) begin
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
         case ($urandom_range(0, 9))
            0:       token_bytes.push_back("_");
            1:       token_bytes.push_back(8'("0" + $urandom_range(0, 9)));
            default: token_bytes.push_back(random_letter());
         endcase
         repeat (n - 1) begin
            case ($urandom_range(0, 3))
               0:       token_bytes.push_back(8'("0" + $urandom_range(0, 9)));
               1:       token_bytes.push_back("_");
               default: token_bytes.push_back(random_letter());
            endcase
         end
      end else if (kind < 70) begin
         // keyword with one thing wrong
         push_text(keyword_text[$urandom_range(0, ltc_pkg::KW_COUNT - 1)]);
         pos = $urandom_range(0, token_bytes.size() - 1);
         case ($urandom_range(0, 3))
            0: token_bytes.push_back($urandom_range(0, 1) ? random_letter() : 8'("_"));
            1: void'(token_bytes.pop_back());
            2: token_bytes[pos] = token_bytes[pos] ^ 8'h20;
            default: token_bytes[pos] = 8'($urandom_range(0, 255));
         endcase
      end else if (kind < 80) begin
         if ($urandom_range(0, 1)) begin
            token_bytes.push_back(8'($urandom_range(32, 126)));
            token_bytes.push_back("=");
         end else begin
            token_bytes.push_back(cmp_heads[$urandom_range(0, 3)]);
            token_bytes.push_back(8'($urandom_range(32, 126)));
         end
      end else if (kind < 90) begin
         repeat ($urandom_range(1, 4)) token_bytes.push_back(8'($urandom_range(32, 126)));
      end else begin
         repeat ($urandom_range(1, 8)) token_bytes.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      rsp_stall = 1'b0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (class_queue.size() == 0) begin
            report_mismatch("result with nothing outstanding", 'x, rsp_token_class);
         end else begin
            expected_class = class_queue.pop_front();
            if (rsp_token_class !== expected_class)
               report_mismatch("token_class", expected_class, rsp_token_class);
         end
      end
   end

   // Ends the run when no transaction moves on either channel for too long
   initial begin
      stuck_cycles = 0;
      while (stuck_cycles < STUCK_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            stuck_cycles = 0;
         else
            stuck_cycles++;
      end
      $display("testbench: FAIL");
      $finish;
   end

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_in_char   = '0;
      req_last_char = 1'b0;
      hold_request  = 1'b0;
      fail_count    = 0;
      sent_items    = 0;
      token_count   = '0;
      token_digits  = 1'b0;
      token_name    = 1'b0;
      send_gap_pct  = 21;
      stall_pct     = 71;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_char(directed_rows[i].ch, directed_rows[i].last, directed_rows[i].typed,
                   directed_rows[i].cls);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_gap_pct = 21;
               stall_pct    = 71;
            end
            1: begin
               send_gap_pct = 71;
               stall_pct    = 21;
            end
            default: begin
               send_gap_pct = 0;
               stall_pct    = 0;
               hold_request = 1'b1;   // long receiver hold while input keeps coming
            end
         endcase
         while (sent_items < (phase + 1) * PHASE_ITEMS) begin
            build_token();
            foreach (token_bytes[i])
               send_char(token_bytes[i], i == token_bytes.size() - 1, 1'b0, '0);
            sent_items += token_bytes.size();
         end
      end

      req_valid <= 1'b0;
      while (class_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule

`default_nettype wire
